[hdl/safb_pkg.sv]
// Package for the SPI/audio ring buffer bridge: buffer geometry, opcodes,
// reply codes and the memory write request type.
// No dependencies; every other file in hdl/ imports it.
package safb_pkg;

    localparam int BUFFER_DEPTH = 256;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH);
    localparam int CMP_W        = (IDX_W > 8) ? IDX_W : 8;

    localparam int S_TDATA_W  = 8;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 24;
    localparam int M_FIELDS_W = 21;

    localparam logic [7:0] REPLY_OK         = 8'h7E;
    localparam logic [7:0] REPLY_FULL_EMPTY = 8'h7F;
    localparam logic [7:0] REPLY_UNDERRUN   = 8'h7D;
    localparam logic [7:0] DAC_IDLE         = 8'h80;
    localparam logic [7:0] SIGN_FLIP        = 8'h80;
    localparam logic [7:0] THRESHOLD_RESET  = 8'd200;
    localparam int         FULL_MARGIN      = 3;

    typedef enum logic [1:0] {
        OP_SPI  = 2'd0,
        OP_ADC  = 2'd1,
        OP_TICK = 2'd2,
        OP_NOP  = 2'd3
    } safb_op_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } safb_wr_t;

endpackage

[hdl/spi_audio_fifo_bridge.sv]
// Top level of the SPI/audio ring buffer bridge.
// Depends on safb_pkg and safb_ring_ram.

// The bridge takes one word per clock on the slave side while the master
// side is not stalled (s_tuser holds the opcode: SPI byte, ADC sample, timer
// tick or no operation; s_tdata holds the data byte) and returns exactly one
// result word per input word on the master side. The sustained rate, with no
// stall on the master side, is one word per cycle: each word performs at most
// one ring buffer write and one ring buffer read, and the single registered
// read port of the sample memory always holds the entry at the current read
// index, so a word never waits for memory. Words are held first in an input
// register, then processed against the buffer state in one pass into the
// result register. The start threshold is written through cfg_we and
// cfg_wdata and should only be changed while no words are in flight. Buffer
// entries never written since reset hold no defined value; the full and
// empty tests keep normal traffic from reading them.
module spi_audio_fifo_bridge (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [7:0]                     cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] data_byte
    input  logic [safb_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] opcode
    input  logic [safb_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] reply_valid, [8:1] reply_byte, [9] dac_write, [17:10] dac_level,
    // [18] ptt_on, [19] adc_trigger, [20] in_playback, [23:21] zero
    output logic [safb_pkg::M_TDATA_W-1:0] m_tdata
);
    import safb_pkg::*;

    // Input register.
    logic       item_valid_reg, item_valid_next;
    safb_op_t   item_op_reg;
    logic [7:0] item_data_reg;

    // Result register.
    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;

    // Buffer and control state.
    logic [IDX_W-1:0] wi_reg, wi_next;
    logic [IDX_W-1:0] ri_reg, ri_next;
    logic             play_mode_reg, play_mode_next;
    logic             started_reg, started_next;
    logic             underrun_reg, underrun_next;
    logic             ptt_reg, ptt_next;
    logic [7:0]       dac_reg, dac_next;
    logic [7:0]       threshold_reg;

    logic             advance;
    logic             s_accept;
    safb_wr_t         wr;
    logic [7:0]       rdata;
    logic [IDX_W-1:0] wi_inc;
    logic [IDX_W-1:0] ri_inc;
    logic [7:0]       flipped;
    logic             rv, dw, trig;
    logic [7:0]       rb;

    // A word moves from the input register to the result register whenever
    // the result register is empty or being emptied.
    assign advance  = item_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign wi_inc  = wi_reg + IDX_W'(1);
    assign ri_inc  = ri_reg + IDX_W'(1);
    assign flipped = item_data_reg ^ SIGN_FLIP;

    always_comb
    begin
        wi_next        = wi_reg;
        ri_next        = ri_reg;
        play_mode_next = play_mode_reg;
        started_next   = started_reg;
        underrun_next  = underrun_reg;
        ptt_next       = ptt_reg;
        dac_next       = dac_reg;
        wr.en          = 1'b0;
        wr.addr        = wi_reg;
        wr.data        = flipped;
        rv             = 1'b0;
        rb             = 8'h00;
        dw             = 1'b0;
        trig           = 1'b0;

        if (advance)
        begin
            case (item_op_reg)
                OP_SPI:
                begin
                    if (!play_mode_reg)
                    begin
                        if (item_data_reg == REPLY_OK)
                        begin
                            play_mode_next = 1'b1;
                            wi_next        = '0;
                            ri_next        = '0;
                            started_next   = 1'b0;
                        end
                        else
                        begin
                            rv = 1'b1;
                            if (wi_reg != ri_reg)
                            begin
                                rb      = rdata;
                                ri_next = ri_inc;
                            end
                            else
                            begin
                                rb = REPLY_FULL_EMPTY;
                            end
                        end
                    end
                    else if (item_data_reg == REPLY_FULL_EMPTY)
                    begin
                        // Back to capture mode: DAC to mid-scale, PTT off.
                        play_mode_next = 1'b0;
                        dac_next       = DAC_IDLE;
                        ptt_next       = 1'b0;
                        wi_next        = '0;
                        ri_next        = '0;
                        dw             = 1'b1;
                    end
                    else if (item_data_reg != REPLY_OK)
                    begin
                        wr.en   = 1'b1;
                        wi_next = wi_inc;
                        if (!started_reg && (CMP_W'(wi_inc) > CMP_W'(threshold_reg)))
                        begin
                            started_next = 1'b1;
                            ptt_next     = 1'b1;
                        end
                        rv = 1'b1;
                        rb = ((wi_inc + IDX_W'(FULL_MARGIN)) != ri_reg) ?
                             REPLY_OK : REPLY_FULL_EMPTY;
                        underrun_next = 1'b0;
                    end
                    else if (underrun_reg)
                    begin
                        rv = 1'b1;
                        rb = REPLY_UNDERRUN;
                    end
                end
                OP_ADC:
                begin
                    // The empty marker is reserved, so it is nudged down by one.
                    wr.en   = 1'b1;
                    wr.data = (flipped == REPLY_FULL_EMPTY) ? REPLY_OK : flipped;
                    wi_next = wi_inc;
                end
                OP_TICK:
                begin
                    if (!play_mode_reg)
                    begin
                        trig = 1'b1;
                    end
                    else if (started_reg)
                    begin
                        dw = 1'b1;
                        if (ri_reg == wi_reg)
                        begin
                            underrun_next  = 1'b1;
                            play_mode_next = 1'b0;
                            dac_next       = DAC_IDLE;
                            ptt_next       = 1'b0;
                            wi_next        = '0;
                            ri_next        = '0;
                        end
                        else
                        begin
                            dac_next = rdata;
                            ri_next  = ri_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // The memory reads at the next read index every cycle, so its output
    // always shows the entry at the current read index.
    safb_ring_ram u_ram (
        .clk   (clk),
        .wr    (wr),
        .raddr (ri_next),
        .rdata (rdata)
    );

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (s_accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (advance)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {(M_TDATA_W - M_FIELDS_W)'(0), play_mode_next, trig, ptt_next,
                            dac_next, dw, rb, rv};
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            wi_reg         <= '0;
            ri_reg         <= '0;
            play_mode_reg  <= 1'b0;
            started_reg    <= 1'b0;
            underrun_reg   <= 1'b0;
            ptt_reg        <= 1'b0;
            dac_reg        <= DAC_IDLE;
            threshold_reg  <= THRESHOLD_RESET;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            m_valid_reg    <= m_valid_next;
            wi_reg         <= wi_next;
            ri_reg         <= ri_next;
            play_mode_reg  <= play_mode_next;
            started_reg    <= started_next;
            underrun_reg   <= underrun_next;
            ptt_reg        <= ptt_next;
            dac_reg        <= dac_next;
            if (cfg_we)
            begin
                threshold_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_op_reg   <= safb_op_t'(s_tuser);
            item_data_reg <= s_tdata;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[hdl/safb_ring_ram.sv]
// Sample ring memory: one write port, one registered read port.
// A write to the address being read in the same cycle is forwarded.
// Depends on safb_pkg.
module safb_ring_ram (
    input  logic                     clk,
    input  safb_pkg::safb_wr_t       wr,
    input  logic [safb_pkg::IDX_W-1:0] raddr,
    output logic [7:0]               rdata
);
    import safb_pkg::*;

    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] mem_q_reg;
    logic [7:0] fwd_data_reg;
    logic       fwd_sel_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        mem_q_reg    <= mem[raddr];
        fwd_data_reg <= wr.data;
        fwd_sel_reg  <= wr.en && (wr.addr == raddr);
    end

    assign rdata = fwd_sel_reg ? fwd_data_reg : mem_q_reg;

endmodule
